### rtl/apq_pkg.sv
// Shared types and codes for the aging priority task queue.
package apq_pkg;

  // Parameter defaults
  localparam int QueueDepthDef = 16;
  localparam int TaskIdsDef    = 256;
  localparam int PrioBitsDef   = 16;

  // Operation codes
  localparam logic [2:0] KindSetPrio    = 3'd0;
  localparam logic [2:0] KindGetPrio    = 3'd1;
  localparam logic [2:0] KindRemovePrio = 3'd2;
  localparam logic [2:0] KindSchedule   = 3'd3;
  localparam logic [2:0] KindRun        = 3'd4;
  localparam logic [2:0] KindIncActive  = 3'd5;
  localparam logic [2:0] KindDecActive  = 3'd6;

  // Result status codes
  localparam logic [2:0] StatDone       = 3'd0;
  localparam logic [2:0] StatDispatched = 3'd1;
  localparam logic [2:0] StatPollWait   = 3'd2;
  localparam logic [2:0] StatIdle       = 3'd3;
  localparam logic [2:0] StatFullDrop   = 3'd4;

  // Configuration register indexes
  localparam logic RegDefaultPrio = 1'b0;
  localparam logic RegPollTimeout = 1'b1;

  // Configuration reset values
  localparam logic signed [15:0] DefaultPrioRst = 16'sd1;
  localparam logic [15:0]        PollTimeoutRst = 16'd10;

  // Active counter limit
  localparam logic [15:0] ActiveMax = 16'hFFFF;

  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         task_id;
    logic signed [15:0] new_priority;
  } cmd_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [7:0]         out_task;
    logic signed [15:0] out_priority;
    logic [15:0]        wait_timeout;
    logic               work_pending;
    logic [4:0]         queue_count;
  } rsp_t;

endpackage

### rtl/aging_priority_task_queue_core.sv
// Aging priority task queue: sorted ready queue, priority table and sequencer.
//
// Usage: present a command on cmd_i and raise start while busy is low; the
// transaction is taken at that clock edge. Set, remove, counter and unused
// commands, schedules of the null task and runs on an empty queue finish in
// that cycle; the result appears on rsp_o with done_o high for exactly one
// cycle after the accepting edge. Get waits for one table read, as does
// a schedule into an empty or full queue. Any other schedule then walks from
// the tail, moving each queue entry with a lower priority than the new task
// back by one before the new task is written. Run reads the head entry, then
// ages and moves each remaining entry forward.
// The queue memory has one write port and one registered read port, and reads
// and writes one entry per cycle under the sequencer. busy is high while a
// transaction is in the sequencer; start is ignored then. A new transaction may
// be started in the cycle that done_o is high.
// Configuration writes (cfg_we_i) take effect at once and must come only
// while the block is idle. The receiver cannot stall: each result is valid
// for its single done_o cycle only.
// Reset empties the queue, invalidates every table entry and the active counter,
// and loads default priority 1 and poll timeout 10. No clearing pass runs.
module aging_priority_task_queue_core #(
  parameter int QUEUE_DEPTH = apq_pkg::QueueDepthDef,
  parameter int TASK_IDS    = apq_pkg::TaskIdsDef,
  parameter int PRIO_BITS   = apq_pkg::PrioBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  apq_pkg::cmd_t cmd_i,
  output logic          done_o,
  output apq_pkg::rsp_t rsp_o,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [15:0]   cfg_wdata_i
);

  localparam int QIdxW    = $clog2(QUEUE_DEPTH);
  localparam int QCntW    = $clog2(QUEUE_DEPTH + 1);
  localparam int TblDepth = (TASK_IDS < 256) ? TASK_IDS : 256;
  localparam int TblIdxW  = $clog2(TblDepth);

  localparam logic signed [32:0] PMaxW = (33'sd1 <<< (PRIO_BITS - 1)) - 33'sd1;
  localparam logic signed [32:0] PMinW = -(33'sd1 <<< (PRIO_BITS - 1));
  localparam logic signed [PRIO_BITS-1:0] PrioMax = PMaxW[PRIO_BITS-1:0];
  localparam logic [QCntW-1:0] QFull = QCntW'(QUEUE_DEPTH);

  // Sequencer states
  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SLook  = 3'd1;
  localparam logic [2:0] SIns   = 3'd2;
  localparam logic [2:0] SPut   = 3'd3;
  localparam logic [2:0] SRHead = 3'd4;
  localparam logic [2:0] SRSh   = 3'd5;

  typedef struct packed {
    logic [7:0]                  task_id;
    logic signed [PRIO_BITS-1:0] prio;
  } qent_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [7:0]         out_task;
    logic signed [15:0] out_priority;
    logic [15:0]        wait_timeout;
  } res_t;

  // Saturate a 16-bit priority into the PRIO_BITS range
  function automatic logic signed [PRIO_BITS-1:0] clamp_prio(logic signed [15:0] v);
    logic signed [32:0] w;
    w = 33'(v);
    if (w > PMaxW) begin
      return PMaxW[PRIO_BITS-1:0];
    end else if (w < PMinW) begin
      return PMinW[PRIO_BITS-1:0];
    end
    return w[PRIO_BITS-1:0];
  endfunction

  // Low 16 bits of a priority, sign-extended when narrower
  function automatic logic signed [15:0] to_out(logic signed [PRIO_BITS-1:0] p);
    logic signed [32:0] w;
    w = 33'(p);
    return w[15:0];
  endfunction

  // Aging step, saturating at the top
  function automatic logic signed [PRIO_BITS-1:0] sat_inc(logic signed [PRIO_BITS-1:0] p);
    return (p == PrioMax) ? p : p + {{(PRIO_BITS-1){1'b0}}, 1'b1};
  endfunction

  // Index just below a queue position
  function automatic logic [QIdxW-1:0] q_rtmp_prev(logic [QCntW-1:0] i);
    logic [QCntW-1:0] t;
    t = i - 1'b1;
    return t[QIdxW-1:0];
  endfunction

  logic [2:0]                  state_q, state_d;
  logic [QCntW-1:0]            used_q, used_d;
  logic [QCntW-1:0]            idx_q, idx_d;
  logic [15:0]                 active_q, active_d;
  logic signed [15:0]          dflt_q;
  logic [15:0]                 poll_q;
  logic [TblDepth-1:0]         vld_q, vld_d;
  logic                        done_q, done_d;
  res_t                        res_q, res_d;
  logic [2:0]                  kind_q, kind_d;
  logic [7:0]                  id_q, id_d;
  logic signed [PRIO_BITS-1:0] prio_q, prio_d;

  // Queue memory
  qent_t                       q_mem [QUEUE_DEPTH];
  qent_t                       q_rd_q;
  logic                        q_we;
  logic [QIdxW-1:0]            q_waddr, q_raddr;
  qent_t                       q_wdata;
  logic [QCntW-1:0]            q_rtmp;

  // Priority table memory
  logic signed [PRIO_BITS-1:0] t_mem [TblDepth];
  logic signed [PRIO_BITS-1:0] t_rd_q;
  logic                        t_we;
  logic [TblIdxW-1:0]          t_raddr, t_waddr;
  logic signed [PRIO_BITS-1:0] t_wdata;

  logic                        accept;
  logic                        in_tbl_new, in_tbl_cur;
  logic [TblIdxW-1:0]          id_idx_new, id_idx_cur;
  logic signed [PRIO_BITS-1:0] np_clamp, look_prio;

  assign accept     = start && !busy;
  assign busy       = (state_q != SIdle);
  assign in_tbl_new = (32'(cmd_i.task_id) < TASK_IDS);
  assign in_tbl_cur = (32'(id_q) < TASK_IDS);
  assign id_idx_new = cmd_i.task_id[TblIdxW-1:0];
  assign id_idx_cur = id_q[TblIdxW-1:0];
  assign np_clamp   = clamp_prio(cmd_i.new_priority);
  assign look_prio  = (in_tbl_cur && vld_q[id_idx_cur]) ? t_rd_q : clamp_prio(dflt_q);
  assign t_raddr    = busy ? id_idx_cur : id_idx_new;

  // Queue read address for the next cycle's data
  always_comb begin
    case (state_q)
      SIdle:   q_rtmp = (cmd_i.kind == apq_pkg::KindRun) ? '0 : used_q - 1'b1;
      SLook:   q_rtmp = used_q - 1'b1;
      SIns:    q_rtmp = idx_q - 2'd2;
      SRHead:  q_rtmp = QCntW'(1);
      SRSh:    q_rtmp = idx_q + 1'b1;
      default: q_rtmp = '0;
    endcase
  end
  assign q_raddr = q_rtmp[QIdxW-1:0];

  // Sequencer
  always_comb begin
    state_d  = state_q;
    used_d   = used_q;
    idx_d    = idx_q;
    active_d = active_q;
    vld_d    = vld_q;
    done_d   = 1'b0;
    res_d    = res_q;
    kind_d   = kind_q;
    id_d     = id_q;
    prio_d   = prio_q;
    q_we     = 1'b0;
    q_waddr  = idx_q[QIdxW-1:0];
    q_wdata  = q_rd_q;
    t_we     = 1'b0;
    t_waddr  = id_idx_new;
    t_wdata  = np_clamp;

    case (state_q)
      SIdle: begin
        if (accept) begin
          kind_d = cmd_i.kind;
          id_d   = cmd_i.task_id;
          res_d  = '{status: apq_pkg::StatDone, out_task: 8'd0,
                     out_priority: 16'sd0, wait_timeout: 16'd0};
          case (cmd_i.kind)
            apq_pkg::KindSetPrio: begin
              if (in_tbl_new) begin
                t_we              = 1'b1;
                vld_d[id_idx_new] = 1'b1;
              end
              res_d.out_task     = cmd_i.task_id;
              res_d.out_priority = to_out(np_clamp);
              done_d             = 1'b1;
            end
            apq_pkg::KindGetPrio: begin
              state_d = SLook;
            end
            apq_pkg::KindRemovePrio: begin
              if (in_tbl_new) begin
                vld_d[id_idx_new] = 1'b0;
              end
              res_d.out_task = cmd_i.task_id;
              done_d         = 1'b1;
            end
            apq_pkg::KindSchedule: begin
              if (cmd_i.task_id == 8'd0) begin
                done_d = 1'b1;
              end else begin
                state_d = SLook;
              end
            end
            apq_pkg::KindRun: begin
              if (used_q != '0) begin
                state_d = SRHead;
              end else begin
                if (active_q != 16'd0) begin
                  res_d.status       = apq_pkg::StatPollWait;
                  res_d.wait_timeout = poll_q;
                end else begin
                  res_d.status = apq_pkg::StatIdle;
                end
                done_d = 1'b1;
              end
            end
            apq_pkg::KindIncActive: begin
              if (active_q != apq_pkg::ActiveMax) begin
                active_d = active_q + 16'd1;
              end
              done_d = 1'b1;
            end
            apq_pkg::KindDecActive: begin
              if (active_q != 16'd0) begin
                active_d = active_q - 16'd1;
              end
              done_d = 1'b1;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      // Table data is back: finish a get or a schedule into an empty or full queue, or start an insertion
      SLook: begin
        prio_d             = look_prio;
        res_d.out_task     = id_q;
        res_d.out_priority = to_out(look_prio);
        if (kind_q != apq_pkg::KindSchedule) begin
          state_d = SIdle;
          done_d  = 1'b1;
        end else if (used_q == QFull) begin
          res_d.status = apq_pkg::StatFullDrop;
          state_d      = SIdle;
          done_d       = 1'b1;
        end else if (used_q == '0) begin
          q_we    = 1'b1;
          q_waddr = '0;
          q_wdata = '{task_id: id_q, prio: look_prio};
          used_d  = used_q + 1'b1;
          state_d = SIdle;
          done_d  = 1'b1;
        end else begin
          idx_d   = used_q;
          state_d = SIns;
        end
      end

      // Walk from the tail, moving lower-priority entries back by one until the new task is placed
      SIns: begin
        q_we = 1'b1;
        if (q_rd_q.prio < prio_q) begin
          q_wdata = q_rd_q;
          idx_d   = idx_q - 1'b1;
          if (idx_q == QCntW'(1)) begin
            state_d = SPut;
          end
        end else begin
          q_wdata = '{task_id: id_q, prio: prio_q};
          used_d  = used_q + 1'b1;
          state_d = SIdle;
          done_d  = 1'b1;
        end
      end

      // New task goes to the head
      SPut: begin
        q_we    = 1'b1;
        q_wdata = '{task_id: id_q, prio: prio_q};
        used_d  = used_q + 1'b1;
        state_d = SIdle;
        done_d  = 1'b1;
      end

      // Head entry is back: report it
      SRHead: begin
        id_d               = q_rd_q.task_id;
        prio_d             = q_rd_q.prio;
        res_d.status       = apq_pkg::StatDispatched;
        res_d.out_task     = q_rd_q.task_id;
        res_d.out_priority = to_out(q_rd_q.prio);
        if (used_q == QCntW'(1)) begin
          used_d  = used_q - 1'b1;
          state_d = SIdle;
          done_d  = 1'b1;
        end else begin
          idx_d   = QCntW'(1);
          state_d = SRSh;
        end
      end

      // Move each remaining entry forward, aging it on the way
      SRSh: begin
        q_we    = 1'b1;
        q_waddr = q_rtmp_prev(idx_q);
        q_wdata = '{task_id: q_rd_q.task_id, prio: sat_inc(q_rd_q.prio)};
        idx_d   = idx_q + 1'b1;
        if (idx_q + 1'b1 == used_q) begin
          used_d  = used_q - 1'b1;
          state_d = SIdle;
          done_d  = 1'b1;
        end
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // Control registers and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      used_q   <= '0;
      idx_q    <= '0;
      active_q <= 16'd0;
      vld_q    <= '0;
      done_q   <= 1'b0;
      dflt_q   <= apq_pkg::DefaultPrioRst;
      poll_q   <= apq_pkg::PollTimeoutRst;
    end else begin
      state_q  <= state_d;
      used_q   <= used_d;
      idx_q    <= idx_d;
      active_q <= active_d;
      vld_q    <= vld_d;
      done_q   <= done_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          apq_pkg::RegDefaultPrio: dflt_q <= cfg_wdata_i;
          apq_pkg::RegPollTimeout: poll_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    kind_q <= kind_d;
    id_q   <= id_d;
    prio_q <= prio_d;
  end

  // Queue memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    q_rd_q <= q_mem[q_raddr];
  end

  // Priority table memory
  always_ff @(posedge clk_i) begin
    if (t_we) begin
      t_mem[t_waddr] <= t_wdata;
    end
    t_rd_q <= t_mem[t_raddr];
  end

  // Result port
  assign done_o             = done_q;
  assign rsp_o.status       = res_q.status;
  assign rsp_o.out_task     = res_q.out_task;
  assign rsp_o.out_priority = res_q.out_priority;
  assign rsp_o.wait_timeout = res_q.wait_timeout;
  assign rsp_o.work_pending = (active_q != 16'd0) || (used_q != '0);
  assign rsp_o.queue_count  = 5'(used_q);

  // Checks
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (done_o || busy))
    else $error("accepted transaction neither finished nor in progress");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while sequencer still busy");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= QFull)
    else $error("queue fill beyond depth");

  a_ins_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SIns) |-> (idx_q != '0 && idx_q <= used_q))
    else $error("insertion walk index out of range");

  a_dispatch_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == apq_pkg::StatDispatched)
      |-> (used_q + 1'b1 == $past(used_q)))
    else $error("dispatch did not remove exactly one entry");

endmodule

### sim/aging_priority_task_queue_core_test.sv
// Self-checking testbench for the aging priority task queue core.
`timescale 1ns / 100ps

module aging_priority_task_queue_core_test;

  localparam logic [2:0] KindUnused = 3'd7;
  localparam int         RdyDepth   = apq_pkg::QueueDepthDef;
  localparam int         NumIds     = apq_pkg::TaskIdsDef;

  logic          clk_i;
  logic          rst_ni;
  logic          start;
  logic          busy;
  apq_pkg::cmd_t cmd_i;
  logic          done_o;
  apq_pkg::rsp_t rsp_o;
  logic          cfg_we_i;
  logic          cfg_idx_i;
  logic [15:0]   cfg_wdata_i;

  aging_priority_task_queue_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Directed stimulus row: command plus optional hand-written response
  typedef struct {
    apq_pkg::cmd_t c;
    bit            typed;
    apq_pkg::rsp_t r;
  } step_row_t;

  // Shadow state of the ready queue, priority table and counters
  logic [7:0]         rdy_task [RdyDepth];
  logic signed [15:0] rdy_prio [RdyDepth];
  int unsigned        rdy_used;
  logic signed [15:0] prio_tbl [NumIds];
  bit                 prio_ok  [NumIds];
  int unsigned        active_cnt;
  logic signed [15:0] dflt_prio;
  logic [15:0]        poll_tmo;

  apq_pkg::rsp_t pending_rsp [$];
  step_row_t     dir_rows [$];
  int            mismatches;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic signed [15:0] prio_of(logic [7:0] id);
    if (prio_ok[id]) return prio_tbl[id];
    return dflt_prio;
  endfunction

  // Apply one transaction to the shadow state and return its response
  function automatic apq_pkg::rsp_t queue_response(apq_pkg::cmd_t c);
    apq_pkg::rsp_t      r;
    int unsigned        pos;
    logic signed [15:0] p;
    r = '0;
    case (c.kind)
      apq_pkg::KindSetPrio: begin
        prio_tbl[c.task_id] = c.new_priority;
        prio_ok[c.task_id]  = 1'b1;
        r.out_task          = c.task_id;
        r.out_priority      = c.new_priority;
      end
      apq_pkg::KindGetPrio: begin
        r.out_task     = c.task_id;
        r.out_priority = prio_of(c.task_id);
      end
      apq_pkg::KindRemovePrio: begin
        prio_ok[c.task_id] = 1'b0;
        r.out_task         = c.task_id;
      end
      apq_pkg::KindSchedule: begin
        if (c.task_id != 8'd0) begin
          p              = prio_of(c.task_id);
          r.out_task     = c.task_id;
          r.out_priority = p;
          if (rdy_used >= RdyDepth) begin
            r.status = apq_pkg::StatFullDrop;
          end else begin
            // behind every entry of greater or equal priority
            pos = 0;
            while (pos < rdy_used && rdy_prio[pos] >= p) pos++;
            for (int unsigned i = rdy_used; i > pos; i--) begin
              rdy_task[i] = rdy_task[i-1];
              rdy_prio[i] = rdy_prio[i-1];
            end
            rdy_task[pos] = c.task_id;
            rdy_prio[pos] = p;
            rdy_used++;
          end
        end
      end
      apq_pkg::KindRun: begin
        if (rdy_used > 0) begin
          r.status       = apq_pkg::StatDispatched;
          r.out_task     = rdy_task[0];
          r.out_priority = rdy_prio[0];
          // shift up and age the rest, saturating at the top
          for (int unsigned i = 1; i < rdy_used; i++) begin
            rdy_task[i-1] = rdy_task[i];
            rdy_prio[i-1] = (rdy_prio[i] == 16'sh7FFF) ? rdy_prio[i] : rdy_prio[i] + 16'sd1;
          end
          rdy_used--;
        end else if (active_cnt > 0) begin
          r.status       = apq_pkg::StatPollWait;
          r.wait_timeout = poll_tmo;
        end else begin
          r.status = apq_pkg::StatIdle;
        end
      end
      apq_pkg::KindIncActive: if (active_cnt < 65535) active_cnt++;
      apq_pkg::KindDecActive: if (active_cnt > 0) active_cnt--;
      default: ;
    endcase
    r.work_pending = (active_cnt != 0) || (rdy_used != 0);
    r.queue_count  = 5'(rdy_used);
    return r;
  endfunction

  // Random command; sched_pct sets how hard the queue is pushed toward full
  function automatic apq_pkg::cmd_t rand_cmd(int unsigned sched_pct);
    apq_pkg::cmd_t c;
    int unsigned   roll;
    roll = $urandom_range(99);
    if (roll < sched_pct) begin
      c.kind = apq_pkg::KindSchedule;
    end else begin
      roll = $urandom_range(99);
      if (roll < 40)      c.kind = apq_pkg::KindRun;
      else if (roll < 60) c.kind = apq_pkg::KindSetPrio;
      else if (roll < 70) c.kind = apq_pkg::KindGetPrio;
      else if (roll < 80) c.kind = apq_pkg::KindRemovePrio;
      else if (roll < 88) c.kind = apq_pkg::KindIncActive;
      else if (roll < 96) c.kind = apq_pkg::KindDecActive;
      else                c.kind = KindUnused;
    end
    // mostly a small id pool so table entries get reused
    roll = $urandom_range(99);
    if (roll < 70)      c.task_id = 8'($urandom_range(12, 1));
    else if (roll < 80) c.task_id = 8'd0;
    else if (roll < 88) c.task_id = 8'hFF;
    else                c.task_id = 8'($urandom_range(255));
    // small values give ties; values near the top exercise aging saturation
    roll = $urandom_range(99);
    if (roll < 50)      c.new_priority = 16'(int'($urandom_range(8)) - 4);
    else if (roll < 65) c.new_priority = 16'sh7FFF - 16'($urandom_range(1));
    else if (roll < 75) c.new_priority = 16'sh8000;
    else                c.new_priority = 16'($urandom);
    return c;
  endfunction

  // Present one transaction, wait for acceptance, record its response
  task automatic send(apq_pkg::cmd_t c, bit typed = 1'b0, apq_pkg::rsp_t e = '0);
    apq_pkg::rsp_t p;
    start <= 1'b1;
    cmd_i <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    p = queue_response(c);
    pending_rsp.push_back(typed ? e : p);
  endtask

  task automatic idle_for(int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Stop sending until every response is back and the core is idle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_rsp.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic signed [15:0] dp, logic [15:0] pt);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= apq_pkg::RegDefaultPrio;
    cfg_wdata_i <= dp;
    @(posedge clk_i);
    cfg_idx_i   <= apq_pkg::RegPollTimeout;
    cfg_wdata_i <= pt;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    dflt_prio = dp;
    poll_tmo  = pt;
  endtask

  task automatic add_row(logic [2:0] k, logic [7:0] id, logic signed [15:0] p,
                         bit typed = 1'b0, apq_pkg::rsp_t e = '0);
    step_row_t row;
    row.c     = '{kind: k, task_id: id, new_priority: p};
    row.typed = typed;
    row.r     = e;
    dir_rows.push_back(row);
  endtask

  // Response checker: the receiver takes every result in its done cycle
  always @(posedge clk_i) begin
    apq_pkg::rsp_t want;
    if (rst_ni && done_o) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: status %0d task %0d prio %0d",
                   rsp_o.status, rsp_o.out_task, rsp_o.out_priority);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_o.status !== want.status || rsp_o.out_task !== want.out_task ||
            rsp_o.out_priority !== want.out_priority ||
            rsp_o.wait_timeout !== want.wait_timeout ||
            rsp_o.work_pending !== want.work_pending ||
            rsp_o.queue_count !== want.queue_count) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("exp/got: status %0d/%0d task %0d/%0d prio %0d/%0d",
                   want.status, rsp_o.status, want.out_task, rsp_o.out_task,
                   want.out_priority, rsp_o.out_priority);
            $display(" wait %0d/%0d pending %0b/%0b count %0d/%0d",
                     want.wait_timeout, rsp_o.wait_timeout,
                     want.work_pending, rsp_o.work_pending,
                     want.queue_count, rsp_o.queue_count);
          end
        end
      end
    end
  end

  // Main sequence
  initial begin
    int unsigned left;
    int unsigned burst;
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    cmd_i       <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= apq_pkg::RegDefaultPrio;
    cfg_wdata_i <= '0;
    mismatches  = 0;
    rdy_used    = 0;
    active_cnt  = 0;
    dflt_prio   = apq_pkg::DefaultPrioRst;
    poll_tmo    = apq_pkg::PollTimeoutRst;
    foreach (prio_ok[i]) prio_ok[i] = 1'b0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty runs, counter floor, table extremes, null and ties
    add_row(apq_pkg::KindRun, 8'd0, 16'sd0, 1,
            apq_pkg::rsp_t'{apq_pkg::StatIdle, 8'd0, 16'sd0, 16'd0, 1'b0, 5'd0});
    add_row(apq_pkg::KindDecActive, 8'hFF, 16'sh7FFF, 1,
            apq_pkg::rsp_t'{apq_pkg::StatDone, 8'd0, 16'sd0, 16'd0, 1'b0, 5'd0});
    add_row(apq_pkg::KindIncActive, 8'd0, 16'sh8000, 1,
            apq_pkg::rsp_t'{apq_pkg::StatDone, 8'd0, 16'sd0, 16'd0, 1'b1, 5'd0});
    add_row(apq_pkg::KindRun, 8'd0, 16'sd0, 1,
            apq_pkg::rsp_t'{apq_pkg::StatPollWait, 8'd0, 16'sd0, 16'd10, 1'b1, 5'd0});
    add_row(apq_pkg::KindDecActive, 8'd0, 16'sd0, 1,
            apq_pkg::rsp_t'{apq_pkg::StatDone, 8'd0, 16'sd0, 16'd0, 1'b0, 5'd0});
    add_row(apq_pkg::KindGetPrio, 8'hFF, 16'sd0, 1,
            apq_pkg::rsp_t'{apq_pkg::StatDone, 8'hFF, 16'sd1, 16'd0, 1'b0, 5'd0});
    add_row(apq_pkg::KindSetPrio, 8'hFF, 16'sh7FFF, 1,
            apq_pkg::rsp_t'{apq_pkg::StatDone, 8'hFF, 16'sh7FFF, 16'd0, 1'b0, 5'd0});
    add_row(apq_pkg::KindSetPrio, 8'd1, 16'sh8000, 1,
            apq_pkg::rsp_t'{apq_pkg::StatDone, 8'd1, 16'sh8000, 16'd0, 1'b0, 5'd0});
    add_row(apq_pkg::KindGetPrio, 8'd1, 16'sd0, 1,
            apq_pkg::rsp_t'{apq_pkg::StatDone, 8'd1, 16'sh8000, 16'd0, 1'b0, 5'd0});
    add_row(apq_pkg::KindSchedule, 8'd0, 16'sd0, 1,
            apq_pkg::rsp_t'{apq_pkg::StatDone, 8'd0, 16'sd0, 16'd0, 1'b0, 5'd0});
    add_row(apq_pkg::KindSchedule, 8'hFF, 16'sd0, 1,
            apq_pkg::rsp_t'{apq_pkg::StatDone, 8'hFF, 16'sh7FFF, 16'd0, 1'b1, 5'd1});
    add_row(apq_pkg::KindSchedule, 8'd1, 16'sd0, 1,
            apq_pkg::rsp_t'{apq_pkg::StatDone, 8'd1, 16'sh8000, 16'd0, 1'b1, 5'd2});
    add_row(apq_pkg::KindSchedule, 8'd7, 16'sd0);
    add_row(apq_pkg::KindSchedule, 8'hFF, 16'sd0);
    add_row(apq_pkg::KindSchedule, 8'd7, 16'sd0);
    add_row(apq_pkg::KindRemovePrio, 8'hFF, 16'sd0, 1,
            apq_pkg::rsp_t'{apq_pkg::StatDone, 8'hFF, 16'sd0, 16'd0, 1'b1, 5'd5});
    add_row(apq_pkg::KindRemovePrio, 8'd200, 16'sd0);
    add_row(apq_pkg::KindGetPrio, 8'hFF, 16'sd0);
    add_row(KindUnused, 8'h55, 16'sh5555);
    repeat (6) add_row(apq_pkg::KindRun, 8'd0, 16'sd0);

    foreach (dir_rows[i]) begin
      send(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].r);
      if ($urandom_range(2) == 0) idle_for($urandom_range(3, 1));
    end

    // Random phases, each under its own register setting
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        1: write_cfg(16'sh7FFF, 16'hFFFF);
        2: write_cfg(16'sh8000, 16'h0000);
        3: write_cfg(16'($urandom), 16'($urandom));
        4: write_cfg(16'sd0, 16'($urandom_range(20, 1)));
        default: ;
      endcase
      left = 100;
      while (left > 0) begin
        burst = $urandom_range(24, 1);
        while (burst > 0 && left > 0) begin
          send(rand_cmd((ph % 2 == 1) ? 65 : 35));
          burst--;
          left--;
        end
        if ($urandom_range(3) != 0) idle_for($urandom_range(8, 1));
      end
    end

    // Active counter up, then down by more than it went up
    drain();
    repeat (3) send('{kind: apq_pkg::KindIncActive, task_id: 8'($urandom),
                      new_priority: 16'sd0});
    repeat (5) send('{kind: apq_pkg::KindDecActive, task_id: 8'd0,
                      new_priority: 16'($urandom)});
    repeat (3) send('{kind: apq_pkg::KindRun, task_id: 8'd0, new_priority: 16'sd0});

    // Wait out the last transaction, then report
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (25) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/apq_pkg.sv
rtl/aging_priority_task_queue_core.sv
sim/aging_priority_task_queue_core_test.sv
